// File: src/ffa_pkg.sv
package ffa_pkg;

	localparam int NUM_FIELDS_DEF = 8;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int SLOT_WORDS     = 16;
	localparam int UNIT_BITS      = 30;

	localparam int IN_W  = 176;
	localparam int OUT_W = 104;

	// field table word indexes
	localparam logic [3:0] W_FLAGS = 4'd0;
	localparam logic [3:0] W_CX    = 4'd1;
	localparam logic [3:0] W_SX    = 4'd4;
	localparam logic [3:0] W_DX    = 4'd7;
	localparam logic [3:0] W_STR   = 4'd10;

	// field types
	localparam logic [1:0] T_VECTOR = 2'd0;
	localparam logic [1:0] T_RADIAL = 2'd1;

	// item kinds
	localparam logic K_WRITE = 1'b0;
	localparam logic K_QUERY = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} clip_t;

	// sign a magnitude and clip it to 32 bits
	function automatic clip_t clip_mag(input logic [63:0] mag, input logic neg);
		clip_t r;
		r.sat = 1'b0;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				r.val = 32'h8000_0000;
				r.sat = 1'b1;
			end else begin
				r.val = 32'(64'd0 - mag);
			end
		end else if (mag > 64'h7FFF_FFFF) begin
			r.val = 32'h7FFF_FFFF;
			r.sat = 1'b1;
		end else begin
			r.val = mag[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/ffa_sqrt.sv
module ffa_sqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [63:0]           rad,
	output ffa_pkg::unit_stat_t   stat,
	output logic [31:0]           root
);
	import ffa_pkg::*;

	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [34:0] rem_sh, trial;
	logic        ge;

	// one result bit per cycle
	assign rem_sh = {rem_q[32:0], rad_q[63:62]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

// File: src/ffa_div.sv
module ffa_div #(
	parameter int NW = 80,
	parameter int DW = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NW-1:0]         num,
	input  logic [DW-1:0]         den,
	output ffa_pkg::unit_stat_t   stat,
	output logic [NW-1:0]         quo
);
	import ffa_pkg::*;

	localparam int CW = $clog2(NW);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   rem_sh, diff;
	logic          ge;

	// restoring division, quotient bits shift in behind the dividend
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = num_q;

endmodule

// File: src/force_field_accumulator.sv
// Force field accumulator. Stream in field table writes (tuser = 0) and body
// force queries (tuser = 1). A write stores one 32-bit word of a field slot
// (flags, center, box size, direction, strength) and gives no result. A query
// sums the force of every active field whose volume holds the body (if flag
// bit 3 is set) and returns one transfer with the per-axis saturated Q16.16
// force, the number of applied fields and a clip flag. Kinematic, sleeping
// or massless bodies return zero. Otherwise the query walks the slots one
// per cycle, stopping at each active field, which first reads its eleven
// words from the field RAM and then gets the box test; a vector field then
// uses the shared multiplier per axis, while a radial field, if the body is
// not near its center, also takes a square root and four passes of the shared
// bit-serial divider of width NW = max(61, 32 + 2*FRAC_BITS). One item is
// worked on at a time; a finished result waits in the output register while
// the next item is taken. No clearing pass is needed after reset.
module force_field_accumulator #(
	parameter int NUM_FIELDS = ffa_pkg::NUM_FIELDS_DEF,
	parameter int FRAC_BITS  = ffa_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// slot[2:0] word_index[6:3] word_value[38:7] body_x[70:39] body_y[102:71]
	// body_z[134:103] body_mass[166:135] body_kinematic[167] body_awake[168]
	input  logic [ffa_pkg::IN_W-1:0]  s_tdata,
	// kind[0]
	input  logic [0:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// force_x[31:0] force_y[63:32] force_z[95:64] fields_applied[99:96]
	// saturated[100]
	output logic [ffa_pkg::OUT_W-1:0] m_tdata
);
	import ffa_pkg::*;

	localparam int SW    = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
	localparam int CW    = $clog2(NUM_FIELDS + 1);
	localparam int AW    = 33 + CW;
	localparam int NW    = (2 * FRAC_BITS + 32 > 61) ? 2 * FRAC_BITS + 32 : 61;
	localparam int DEPTH = NUM_FIELDS * SLOT_WORDS;
	localparam logic [63:0] NEAR_LIMIT =
		((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_SCAN  = 17'b00000000000000010,
		S_LOAD  = 17'b00000000000000100,
		S_EVAL  = 17'b00000000000001000,
		S_VMUL  = 17'b00000000000010000,
		S_VTERM = 17'b00000000000100000,
		S_RAD   = 17'b00000000001000000,
		S_SQ    = 17'b00000000010000000,
		S_NEAR  = 17'b00000000100000000,
		S_SQRT  = 17'b00000001000000000,
		S_MDIV  = 17'b00000010000000000,
		S_DIVM  = 17'b00000100000000000,
		S_UDIV  = 17'b00001000000000000,
		S_DIVU  = 17'b00010000000000000,
		S_MUL   = 17'b00100000000000000,
		S_TERM  = 17'b01000000000000000,
		S_OUT   = 17'b10000000000000000
	} state_t;

	// input unpacking
	logic        in_kind;
	logic [2:0]  in_slot;
	logic [3:0]  in_widx;
	logic [31:0] in_word, in_mass;
	logic [31:0] in_pos [0:2];
	logic        in_kin, in_awake;

	assign in_kind   = s_tuser[0];
	assign in_slot   = s_tdata[2:0];
	assign in_widx   = s_tdata[6:3];
	assign in_word   = s_tdata[38:7];
	assign in_pos[0] = s_tdata[70:39];
	assign in_pos[1] = s_tdata[102:71];
	assign in_pos[2] = s_tdata[134:103];
	assign in_mass   = s_tdata[166:135];
	assign in_kin    = s_tdata[167];
	assign in_awake  = s_tdata[168];

	state_t          state_q;
	logic            accept;
	logic [CW-1:0]   fld_q;
	logic [NUM_FIELDS-1:0] active_q;
	logic [31:0]     pos_q [0:2];
	logic [31:0]     wrd_q [0:10];
	logic [3:0]      widx_q;
	logic            rd_vld_s1;
	logic [3:0]      rd_idx_s1;
	logic [31:0]     rdata_s1;
	logic [1:0]      ax_q;
	logic [3:0]      count_q;
	logic            sat_q;
	logic [AW-1:0]   acc_q [0:2];
	logic [32:0]     d_q [0:2];
	logic [30:0]     b_q [0:2];
	logic [2:0]      neg_q;
	logic            sh_q;
	logic [63:0]     q_q;
	logic [31:0]     r_q;
	logic [32:0]     m_q;
	logic            over_q;
	logic [30:0]     u_q;
	logic [65:0]     mul_s1;
	logic            m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	// field parameter RAM
	logic [31:0]     mem [0:DEPTH-1];
	logic            wr_en, rd_en;
	logic [SW+3:0]   wr_addr, rd_addr;
	logic [3:0]      rd_word;

	logic            fld_done, fld_act;
	assign fld_done = (fld_q == CW'(NUM_FIELDS));
	assign fld_act  = !fld_done && active_q[fld_q[SW-1:0]];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign wr_en   = accept && (in_kind == K_WRITE) && (32'(in_slot) < NUM_FIELDS)
		&& (in_widx <= W_STR);
	assign wr_addr = {SW'(in_slot), in_widx};
	assign rd_en   = ((state_q == S_SCAN) && fld_act)
		|| ((state_q == S_LOAD) && (widx_q <= W_STR));
	assign rd_word = (state_q == S_SCAN) ? W_FLAGS : widx_q;
	assign rd_addr = {fld_q[SW-1:0], rd_word};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= in_word;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// current field words
	logic [31:0] flags, strength;
	logic [1:0]  ftype;
	assign flags    = wrd_q[W_FLAGS];
	assign strength = wrd_q[W_STR];
	assign ftype    = flags[2:1];

	// per-axis selection
	logic [31:0] cur_dir;
	logic [30:0] cur_b;
	logic        cur_neg;
	logic [AW-1:0] cur_acc;
	always_comb begin
		case (ax_q)
			2'd0: begin
				cur_dir = wrd_q[W_DX];
				cur_b   = b_q[0];
				cur_neg = neg_q[0];
				cur_acc = acc_q[0];
			end
			2'd1: begin
				cur_dir = wrd_q[W_DX + 4'd1];
				cur_b   = b_q[1];
				cur_neg = neg_q[1];
				cur_acc = acc_q[1];
			end
			2'd2: begin
				cur_dir = wrd_q[W_DX + 4'd2];
				cur_b   = b_q[2];
				cur_neg = neg_q[2];
				cur_acc = acc_q[2];
			end
			default: begin
				cur_dir = '0;
				cur_b   = '0;
				cur_neg = 1'b0;
				cur_acc = '0;
			end
		endcase
	end

	// box test, exact on doubled coordinates
	logic in_box;
	always_comb begin
		logic signed [34:0] p2, c2, z, lo, hi;
		in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			p2 = {pos_q[i][31], pos_q[i][31], pos_q[i], 1'b0};
			c2 = {wrd_q[W_CX + 4'(i)][31], wrd_q[W_CX + 4'(i)][31],
				wrd_q[W_CX + 4'(i)], 1'b0};
			z  = {{3{wrd_q[W_SX + 4'(i)][31]}}, wrd_q[W_SX + 4'(i)]};
			lo = c2 - z;
			hi = c2 + z;
			if (p2 < lo || p2 > hi) begin
				in_box = 1'b0;
			end
		end
	end

	// radial offsets: magnitude, range shift
	logic [32:0] absd [0:2];
	logic        sh_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			absd[i] = d_q[i][32] ? (33'd0 - d_q[i]) : d_q[i];
		end
		sh_c = absd[0][31] | absd[1][31] | absd[2][31];
	end

	// shared multiplier, one register behind it
	logic signed [32:0] mul_a, mul_b;
	always_comb begin
		case (state_q)
			S_SQ: begin
				mul_a = {2'b00, cur_b};
				mul_b = {2'b00, cur_b};
			end
			S_MUL: begin
				mul_a = {1'b0, m_q[31:0]};
				mul_b = {2'b00, u_q};
			end
			S_VMUL: begin
				mul_a = {cur_dir[31], cur_dir};
				mul_b = {strength[31], strength};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_s1 <= mul_a * mul_b;
	end

	// term magnitudes
	logic [65:0] vabs;
	logic [63:0] vmag, rprod, rmag;
	clip_t       vclip, rclip;
	assign vabs  = mul_s1[65] ? (66'd0 - mul_s1) : mul_s1;
	assign vmag  = 64'(vabs >> FRAC_BITS);
	assign vclip = clip_mag(vmag, mul_s1[65]);
	assign rprod = mul_s1[63:0] + (m_q[32] ? ({33'd0, u_q} << 32) : 64'd0);
	always_comb begin
		if (u_q == '0) begin
			rmag = '0;
		end else if (over_q) begin
			rmag = 64'd1 << 32;
		end else begin
			rmag = rprod >> UNIT_BITS;
		end
	end
	assign rclip = clip_mag(rmag, cur_neg);

	// shared square root and divider
	unit_stat_t  sq_stat, dv_stat;
	logic        sq_start, dv_start;
	logic [31:0] sq_root;
	logic [NW-1:0] dv_num, dv_quo;
	logic [63:0] dv_den;
	logic [31:0] abs_s;
	logic        near;

	assign near     = !sh_q && (q_q < NEAR_LIMIT);
	assign sq_start = (state_q == S_NEAR) && !near;
	assign dv_start = (state_q == S_MDIV) || (state_q == S_UDIV);
	assign abs_s    = strength[31] ? (32'd0 - strength) : strength;
	always_comb begin
		if (state_q == S_MDIV) begin
			dv_num = sh_q ? (NW'(abs_s) << (2 * FRAC_BITS - 2))
				: (NW'(abs_s) << (2 * FRAC_BITS));
			dv_den = q_q;
		end else begin
			dv_num = NW'(cur_b) << UNIT_BITS;
			dv_den = {32'd0, r_q};
		end
	end

	ffa_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (q_q),
		.stat   (sq_stat),
		.root   (sq_root)
	);

	ffa_div #(
		.NW (NW),
		.DW (64)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.stat   (dv_stat),
		.quo    (dv_quo)
	);

	// final per-axis saturation
	function automatic clip_t clip_acc(input logic [AW-1:0] a);
		clip_t r;
		logic signed [AW-1:0] s;
		s     = a;
		r.sat = 1'b0;
		r.val = a[31:0];
		if (s > AW'(64'sh7FFF_FFFF)) begin
			r.val = 32'h7FFF_FFFF;
			r.sat = 1'b1;
		end else if (s < -AW'(64'sh8000_0000)) begin
			r.val = 32'h8000_0000;
			r.sat = 1'b1;
		end
		return r;
	endfunction

	clip_t fx, fy, fz;
	assign fx = clip_acc(acc_q[0]);
	assign fy = clip_acc(acc_q[1]);
	assign fz = clip_acc(acc_q[2]);

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	logic inert;
	assign inert = in_kin || !in_awake || ($signed(in_mass) <= 32'sd0);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= '0;
			fld_q      <= '0;
			widx_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			ax_q       <= '0;
			count_q    <= '0;
			sat_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			rd_idx_s1 <= rd_word;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_kind == K_WRITE) begin
							if (wr_en && (in_widx == W_FLAGS)) begin
								active_q[SW'(in_slot)] <= in_word[0];
							end
						end else begin
							count_q <= '0;
							sat_q   <= 1'b0;
							fld_q   <= '0;
							state_q <= inert ? S_OUT : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (fld_done) begin
						state_q <= S_OUT;
					end else if (fld_act) begin
						widx_q  <= W_FLAGS + 4'd1;
						state_q <= S_LOAD;
					end else begin
						fld_q <= fld_q + 1'b1;
					end
				end
				S_LOAD: begin
					if (widx_q <= W_STR) begin
						widx_q <= widx_q + 4'd1;
					end
					if (rd_vld_s1 && (rd_idx_s1 == W_STR)) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					ax_q <= '0;
					if (flags[3] && !in_box) begin
						fld_q   <= fld_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						if (count_q != 4'hF) begin
							count_q <= count_q + 4'd1;
						end
						case (ftype)
							T_VECTOR: state_q <= S_VMUL;
							T_RADIAL: state_q <= S_RAD;
							default: begin
								fld_q   <= fld_q + 1'b1;
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_VMUL: state_q <= S_VTERM;
				S_VTERM: begin
					sat_q <= sat_q | vclip.sat;
					if (ax_q == 2'd2) begin
						fld_q   <= fld_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_VMUL;
					end
				end
				S_RAD: begin
					ax_q    <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (ax_q == 2'd3) begin
						state_q <= S_NEAR;
					end
					ax_q <= ax_q + 2'd1;
				end
				S_NEAR: begin
					if (near) begin
						fld_q   <= fld_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_stat.done) begin
						state_q <= S_MDIV;
					end
				end
				S_MDIV: state_q <= S_DIVM;
				S_DIVM: begin
					if (dv_stat.done) begin
						ax_q    <= '0;
						state_q <= S_UDIV;
					end
				end
				S_UDIV: state_q <= S_DIVU;
				S_DIVU: begin
					if (dv_stat.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_TERM;
				S_TERM: begin
					sat_q <= sat_q | rclip.sat;
					if (ax_q == 2'd2) begin
						fld_q   <= fld_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_UDIV;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && (in_kind == K_QUERY)) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= in_pos[i];
				acc_q[i] <= '0;
			end
		end
		if (rd_vld_s1) begin
			wrd_q[rd_idx_s1] <= rdata_s1;
		end
		if (state_q == S_EVAL) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i] <= {pos_q[i][31], pos_q[i]}
					- {wrd_q[W_CX + 4'(i)][31], wrd_q[W_CX + 4'(i)]};
			end
		end
		if (state_q == S_RAD) begin
			sh_q <= sh_c;
			q_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				b_q[i]   <= sh_c ? absd[i][31:1] : absd[i][30:0];
				neg_q[i] <= d_q[i][32] ^ strength[31] ^ flags[4];
			end
		end
		if ((state_q == S_SQ) && (ax_q != 2'd0)) begin
			q_q <= q_q + mul_s1[63:0];
		end
		if ((state_q == S_SQRT) && sq_stat.done) begin
			r_q <= sq_root;
		end
		if ((state_q == S_DIVM) && dv_stat.done) begin
			m_q    <= dv_quo[32:0];
			over_q <= |dv_quo[NW-1:33];
		end
		if ((state_q == S_DIVU) && dv_stat.done) begin
			u_q <= dv_quo[30:0];
		end
		if (state_q == S_VTERM) begin
			acc_q[ax_q] <= cur_acc + {{(AW-32){vclip.val[31]}}, vclip.val};
		end
		if (state_q == S_TERM) begin
			acc_q[ax_q] <= cur_acc + {{(AW-32){rclip.val[31]}}, rclip.val};
		end
		if (out_load) begin
			m_tdata_q <= {3'b000, sat_q | fx.sat | fy.sat | fz.sat, count_q,
				fz.val, fy.val, fx.val};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start |-> !dv_stat.busy)
		else $error("divider restarted while busy");

	a_sqrt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> (q_q != 64'd0))
		else $error("square root of zero distance");

	a_eval_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> !rd_vld_s1)
		else $error("field words still in flight at evaluation");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) <= NUM_FIELDS))
		else $error("applied field count above table size");

endmodule
